// ===== sv/skmj_pkg.sv =====
// Package for the sorted-key merge join block.
// Holds sizes, command codes and the lane/merge compare structs.
// No dependencies.
package skmj_pkg;

    localparam int MAX_ROWS        = 1024;
    localparam int MAX_KEY_COLUMNS = 4;
    localparam int KEY_WIDTH       = 64;

    localparam int INPUT_KEY_COLUMNS = 4;
    localparam int IN_KEY_W          = 64;
    localparam int ROW_NUM_W         = 11;
    localparam int CFG_W             = 3;
    localparam int CFG_ADDR_W        = 3;
    localparam int DATA_W            = 32;

    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W = $clog2(MAX_ROWS);
    localparam int NCOL_W = $clog2(MAX_KEY_COLUMNS + 1);

    localparam logic [CFG_W-1:0] KEY_COLS_RESET = CFG_W'(1);
    localparam logic             REG_KEY_COLS   = 1'b0;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_PROBE  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic lt;
        logic gt;
    } lane_cmp_t;

    typedef struct packed {
        logic above;
        logic equal;
    } cmp_result_t;

endpackage

// ===== sv/sorted_key_merge_join.sv =====
// Top level of the sorted-key merge join: command port, APB register,
// row counters and cursor control. Depends on skmj_pkg, skmj_lane, skmj_merge.
//
// Usage: an item is taken when start is high and busy is low. command
// selects append (right row into the key table), probe (left row) or clear
// (counters and cursor to zero). Keys of all columns are stored in parallel
// lanes, one column store per lane, and compared side by side; a merge stage
// combines the lane results in column order.
// Append, clear and unused commands leave busy low, as does a probe that
// finds no right row left or comes with the left count full. Otherwise a
// probe holds busy high while the cursor skips right rows below its key;
// each lane store reads one row per cycle at the next cursor. The skip ends
// at the first right row not below the key or past the last right row.
// A match raises result_valid for exactly one cycle, in the cycle after the
// compare, with left_row_number and right_row_number (both 1-based).
// The next item may be started in that same cycle. Results cannot be held off.
// Reset clears the counters, the cursor and key_columns_used (to 1); the
// table content is undefined until appended. The register key_columns_used
// sits at byte address 0 of the APB port; write it only while busy is low.
module sorted_key_merge_join (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [1:0]                        command,
    input  logic [skmj_pkg::IN_KEY_W-1:0]     key_col0,
    input  logic [skmj_pkg::IN_KEY_W-1:0]     key_col1,
    input  logic [skmj_pkg::IN_KEY_W-1:0]     key_col2,
    input  logic [skmj_pkg::IN_KEY_W-1:0]     key_col3,
    output logic                              busy,
    output logic                              result_valid,
    output logic [skmj_pkg::ROW_NUM_W-1:0]    left_row_number,
    output logic [skmj_pkg::ROW_NUM_W-1:0]    right_row_number,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [skmj_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [skmj_pkg::DATA_W-1:0]       pwdata,
    output logic [skmj_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import skmj_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'b01,
        ST_COMPARE = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  right_count_reg, right_count_next;
    logic [ROW_W-1:0]  right_cursor_reg, right_cursor_next;
    logic [ROW_W-1:0]  left_count_reg, left_count_next;
    logic [CFG_W-1:0]  key_cols_reg;
    logic              result_valid_reg, result_valid_next;
    logic [ROW_NUM_W-1:0] left_num_reg, left_num_next;
    logic [ROW_NUM_W-1:0] right_num_reg, right_num_next;

    logic              accept;
    logic              cfg_write;
    logic              tbl_we;
    logic              key_load;
    logic [ROW_W-1:0]  cursor_inc;
    logic [IN_KEY_W-1:0] in_keys [INPUT_KEY_COLUMNS];
    logic [KEY_WIDTH-1:0] lane_keys [MAX_KEY_COLUMNS];
    lane_cmp_t [MAX_KEY_COLUMNS-1:0] lane_cmp;
    cmp_result_t       merged;

    assign in_keys[0] = key_col0;
    assign in_keys[1] = key_col1;
    assign in_keys[2] = key_col2;
    assign in_keys[3] = key_col3;

    genvar g;
    generate
        for (g = 0; g < MAX_KEY_COLUMNS; g++)
        begin : g_lane
            if (g < INPUT_KEY_COLUMNS)
            begin : g_in
                assign lane_keys[g] = in_keys[g][KEY_WIDTH-1:0];
            end
            else
            begin : g_zero
                assign lane_keys[g] = '0;
            end

            skmj_lane u_lane (
                .clk      (clk),
                .wr_en    (tbl_we),
                .wr_addr  (right_count_reg[ADDR_W-1:0]),
                .wr_data  (lane_keys[g]),
                .rd_addr  (right_cursor_next[ADDR_W-1:0]),
                .key_load (key_load),
                .key_in   (lane_keys[g]),
                .cmp      (lane_cmp[g])
            );
        end
    endgenerate

    skmj_merge u_merge (
        .key_cols (key_cols_reg),
        .lanes    (lane_cmp),
        .result   (merged)
    );

    assign busy       = (state_reg == ST_COMPARE);
    assign accept     = start && !busy;
    assign cursor_inc = right_cursor_reg + 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        right_count_next  = right_count_reg;
        right_cursor_next = right_cursor_reg;
        left_count_next   = left_count_reg;
        result_valid_next = 1'b0;
        left_num_next     = left_num_reg;
        right_num_next    = right_num_reg;
        tbl_we            = 1'b0;
        key_load          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_APPEND:
                        begin
                            if (right_count_reg < ROW_W'(MAX_ROWS))
                            begin
                                tbl_we           = 1'b1;
                                right_count_next = right_count_reg + 1'b1;
                            end
                        end
                        CMD_PROBE:
                        begin
                            if (left_count_reg < ROW_W'(MAX_ROWS))
                            begin
                                left_count_next = left_count_reg + 1'b1;
                                key_load        = 1'b1;
                                if (right_cursor_reg < right_count_reg)
                                begin
                                    state_next = ST_COMPARE;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            right_count_next  = '0;
                            right_cursor_next = '0;
                            left_count_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_COMPARE:
            begin
                if (merged.above)
                begin
                    right_cursor_next = cursor_inc;
                    if (cursor_inc >= right_count_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (merged.equal)
                begin
                    right_cursor_next = cursor_inc;
                    result_valid_next = 1'b1;
                    left_num_next     = ROW_NUM_W'(left_count_reg);
                    right_num_next    = ROW_NUM_W'(cursor_inc);
                    state_next        = ST_IDLE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            right_count_reg  <= '0;
            right_cursor_reg <= '0;
            left_count_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            right_count_reg  <= right_count_next;
            right_cursor_reg <= right_cursor_next;
            left_count_reg   <= left_count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_num_reg  <= left_num_next;
        right_num_reg <= right_num_next;
    end

    assign result_valid     = result_valid_reg;
    assign left_row_number  = left_num_reg;
    assign right_row_number = right_num_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cols_reg <= KEY_COLS_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_KEY_COLS))
        begin
            key_cols_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_KEY_COLS) ? DATA_W'(key_cols_reg) : '0;

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        right_cursor_reg <= right_count_reg)
        else $error("cursor beyond right row count");

    a_busy_row_left: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (right_cursor_reg < right_count_reg))
        else $error("compare running with no right row left");

    a_result_from_compare: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_COMPARE))
        else $error("result without a compare cycle");

    a_result_advances: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (right_num_reg == ROW_NUM_W'(right_cursor_reg)))
        else $error("result row does not match cursor");

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_count_reg <= ROW_W'(MAX_ROWS))
        else $error("left row count beyond capacity");

endmodule

// ===== sv/skmj_lane.sv =====
// One key-column lane: column store of the right table, probe key register
// and a magnitude compare of the two. Depends on skmj_pkg.
module skmj_lane (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [skmj_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [skmj_pkg::KEY_WIDTH-1:0] wr_data,
    input  logic [skmj_pkg::ADDR_W-1:0]   rd_addr,
    input  logic                          key_load,
    input  logic [skmj_pkg::KEY_WIDTH-1:0] key_in,
    output skmj_pkg::lane_cmp_t           cmp
);
    import skmj_pkg::*;

    logic [KEY_WIDTH-1:0] mem [MAX_ROWS];
    logic [KEY_WIDTH-1:0] rd_data_reg;
    logic [KEY_WIDTH-1:0] key_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (key_load)
        begin
            key_reg <= key_in;
        end
    end

    assign cmp.lt = key_reg < rd_data_reg;
    assign cmp.gt = key_reg > rd_data_reg;

endmodule

// ===== sv/skmj_merge.sv =====
// Merge stage: clamps the column count and combines the lane compares
// lexicographically, column zero first. Depends on skmj_pkg.
module skmj_merge (
    input  logic [skmj_pkg::CFG_W-1:0]                  key_cols,
    input  skmj_pkg::lane_cmp_t [skmj_pkg::MAX_KEY_COLUMNS-1:0] lanes,
    output skmj_pkg::cmp_result_t                       result
);
    import skmj_pkg::*;

    logic [NCOL_W-1:0] active_cols;

    always_comb
    begin
        if (key_cols == '0)
        begin
            active_cols = NCOL_W'(1);
        end
        else if (int'(key_cols) > MAX_KEY_COLUMNS)
        begin
            active_cols = NCOL_W'(MAX_KEY_COLUMNS);
        end
        else
        begin
            active_cols = NCOL_W'(key_cols);
        end
    end

    always_comb
    begin
        result.above = 1'b0;
        result.equal = 1'b1;
        for (int c = MAX_KEY_COLUMNS - 1; c >= 0; c--)
        begin
            if ((c < int'(active_cols)) && (lanes[c].lt || lanes[c].gt))
            begin
                result.above = lanes[c].gt;
                result.equal = 1'b0;
            end
        end
    end

endmodule

// ===== test/sorted_key_merge_join_tb.sv =====
// Testbench for sorted_key_merge_join: directed and random merge-join runs checked
// against an in-bench join predictor, with key_columns_used written over APB.
// Depends on skmj_pkg and sorted_key_merge_join.
module sorted_key_merge_join_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skmj_pkg::*;

    localparam logic [1:0]            CMD_UNUSED    = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] KEY_COLS_ADDR = CFG_ADDR_W'(4 * int'(REG_KEY_COLS));
    localparam logic [IN_KEY_W-1:0]   KEY_MAX       = {IN_KEY_W{1'b1}};

    typedef logic [INPUT_KEY_COLUMNS-1:0][IN_KEY_W-1:0] key_row_t;

    typedef struct packed {
        logic [ROW_NUM_W-1:0] left_row;
        logic [ROW_NUM_W-1:0] right_row;
    } row_pair_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic [1:0]            command;
    logic [IN_KEY_W-1:0]   key_col0;
    logic [IN_KEY_W-1:0]   key_col1;
    logic [IN_KEY_W-1:0]   key_col2;
    logic [IN_KEY_W-1:0]   key_col3;
    logic                  busy;
    logic                  result_valid;
    logic [ROW_NUM_W-1:0]  left_row_number;
    logic [ROW_NUM_W-1:0]  right_row_number;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    key_row_t         right_keys [MAX_ROWS];
    int               right_count = 0;
    int               right_cursor = 0;
    int               left_count = 0;
    logic [CFG_W-1:0] cols_cfg = KEY_COLS_RESET;
    row_pair_t        pending_matches [$];
    int               errors = 0;
    bit               idle_enable = 1'b1;

    sorted_key_merge_join uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .command          (command),
        .key_col0         (key_col0),
        .key_col1         (key_col1),
        .key_col2         (key_col2),
        .key_col3         (key_col3),
        .busy             (busy),
        .result_valid     (result_valid),
        .left_row_number  (left_row_number),
        .right_row_number (right_row_number),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [IN_KEY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic key_row_t make_row(input logic [IN_KEY_W-1:0] k0,
                                          input logic [IN_KEY_W-1:0] k1,
                                          input logic [IN_KEY_W-1:0] k2,
                                          input logic [IN_KEY_W-1:0] k3);
        return {k3, k2, k1, k0};
    endfunction

    function automatic key_row_t random_row();
        return make_row(rand64(), rand64(), rand64(), rand64());
    endfunction

    function automatic int effective_key_columns();
        int n;
        n = int'(cols_cfg);
        if (n < 1)
            n = 1;
        if (n > MAX_KEY_COLUMNS)
            n = MAX_KEY_COLUMNS;
        return n;
    endfunction

    // -1: probe below row, 0: equal, +1: probe above row
    function automatic int key_order(input key_row_t probe, input int row_idx);
        int n;
        n = effective_key_columns();
        for (int c = 0; c < n; c++)
        begin
            if (probe[c] < right_keys[row_idx][c])
                return -1;
            if (probe[c] > right_keys[row_idx][c])
                return 1;
        end
        return 0;
    endfunction

    function automatic void predict_matches(input logic [1:0] cmd, input key_row_t row);
        case (cmd)
            CMD_APPEND:
            begin
                if (right_count < MAX_ROWS)
                begin
                    right_keys[right_count] = row;
                    right_count++;
                end
            end
            CMD_CLEAR:
            begin
                right_count  = 0;
                right_cursor = 0;
                left_count   = 0;
            end
            CMD_PROBE:
            begin
                if (left_count < MAX_ROWS)
                begin
                    left_count++;
                    while (right_cursor < right_count && key_order(row, right_cursor) > 0)
                        right_cursor++;
                    if (right_cursor < right_count && key_order(row, right_cursor) == 0)
                    begin
                        right_cursor++;
                        pending_matches.push_back('{ROW_NUM_W'(left_count),
                                                    ROW_NUM_W'(right_cursor)});
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_item(input logic [1:0] cmd, input key_row_t row);
        int gap;
        gap = idle_enable ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        command  <= cmd;
        key_col0 <= row[0];
        key_col1 <= row[1];
        key_col2 <= row[2];
        key_col3 <= row[3];
        do @(posedge clk); while (busy);
        predict_matches(cmd, row);
    endtask

    task automatic send_col0(input logic [1:0] cmd, input logic [IN_KEY_W-1:0] k0);
        send_item(cmd, make_row(k0, rand64(), rand64(), rand64()));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (busy || pending_matches.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        while (busy || pending_matches.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_key_columns(input logic [CFG_W-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEY_COLS_ADDR;
        pwdata  <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cols_cfg = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== DATA_W'(value))
        begin
            errors++;
            $display("%0t: key_columns_used readback expected %0d actual %0d",
                     $time, value, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        row_pair_t want;
        if (rst_n && result_valid)
        begin
            if (pending_matches.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item expected none actual left %0d right %0d",
                         $time, left_row_number, right_row_number);
            end
            else
            begin
                want = pending_matches.pop_front();
                if (left_row_number !== want.left_row)
                begin
                    errors++;
                    $display("%0t: left_row_number expected %0d actual %0d",
                             $time, want.left_row, left_row_number);
                end
                if (right_row_number !== want.right_row)
                begin
                    errors++;
                    $display("%0t: right_row_number expected %0d actual %0d",
                             $time, want.right_row, right_row_number);
                end
            end
        end
    end

    task automatic test_single_column();
        write_key_columns(3'd0);
        send_col0(CMD_PROBE, 64'd9);
        send_col0(CMD_APPEND, '0);
        send_col0(CMD_APPEND, 64'd5);
        send_col0(CMD_APPEND, 64'd5);
        send_col0(CMD_APPEND, KEY_MAX);
        send_col0(CMD_PROBE, '0);
        send_col0(CMD_PROBE, 64'd3);
        send_col0(CMD_PROBE, 64'd5);
        send_col0(CMD_PROBE, 64'd5);
        send_col0(CMD_PROBE, 64'd6);
        send_col0(CMD_PROBE, KEY_MAX);
        send_col0(CMD_PROBE, KEY_MAX);
        send_item(CMD_UNUSED, random_row());
        send_item(CMD_CLEAR, random_row());
    endtask

    task automatic test_multi_column();
        write_key_columns(3'd4);
        send_item(CMD_CLEAR, random_row());
        send_item(CMD_APPEND, make_row(64'd1, 64'd2, 64'd3, 64'd4));
        send_item(CMD_APPEND, make_row(64'd1, 64'd2, 64'd3, 64'd5));
        send_item(CMD_APPEND, make_row(64'd1, 64'd3, 64'd0, 64'd0));
        send_item(CMD_APPEND, make_row(64'd2, 64'd0, 64'd0, 64'd0));
        send_item(CMD_PROBE, make_row(64'd1, 64'd2, 64'd3, 64'd4));
        send_item(CMD_PROBE, make_row(64'd1, 64'd2, 64'd3, 64'd4));
        send_item(CMD_PROBE, make_row(64'd1, 64'd2, 64'd3, 64'd6));
        send_item(CMD_PROBE, make_row(64'd1, 64'd3, 64'd0, 64'd0));
        send_item(CMD_PROBE, make_row(64'd2, 64'd0, 64'd0, 64'd0));
        write_key_columns(3'd5);
        send_item(CMD_CLEAR, random_row());
        send_item(CMD_APPEND, make_row(64'd1, 64'd2, 64'd3, 64'd4));
        send_item(CMD_PROBE, make_row(64'd1, 64'd2, 64'd3, 64'd5));
    endtask

    task automatic test_right_table_full();
        logic [IN_KEY_W-1:0] k2;
        k2 = 64'hA5A5_5A5A_0FF0_F00F;
        write_key_columns(3'd6);
        send_item(CMD_CLEAR, random_row());
        for (int i = 0; i < MAX_ROWS + 2; i++)
            send_item(CMD_APPEND, make_row(64'(i), KEY_MAX, k2, '0));
        send_item(CMD_PROBE, make_row(64'(MAX_ROWS - 1), KEY_MAX, k2, '0));
        send_item(CMD_PROBE, make_row(64'(MAX_ROWS), KEY_MAX, k2, '0));
        send_item(CMD_PROBE, make_row(64'(MAX_ROWS + 1), KEY_MAX, k2, '0));
    endtask

    task automatic test_left_count_full();
        write_key_columns(3'd3);
        send_item(CMD_CLEAR, random_row());
        send_item(CMD_APPEND, make_row(64'd5, 64'd7, KEY_MAX, rand64()));
        send_item(CMD_APPEND, make_row(64'd6, 64'd7, KEY_MAX, rand64()));
        for (int i = 0; i < MAX_ROWS - 1; i++)
            send_item(CMD_PROBE, make_row('0, 64'd7, KEY_MAX, rand64()));
        send_item(CMD_PROBE, make_row(64'd5, 64'd7, KEY_MAX, rand64()));
        send_item(CMD_PROBE, make_row(64'd6, 64'd7, KEY_MAX, rand64()));
        send_item(CMD_CLEAR, random_row());
        send_item(CMD_APPEND, make_row(64'd6, 64'd7, KEY_MAX, rand64()));
        send_item(CMD_PROBE, make_row(64'd6, 64'd7, KEY_MAX, rand64()));
    endtask

    function automatic logic [IN_KEY_W-1:0] start_key();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return KEY_MAX - 64'($urandom_range(0, 20));
            default: return rand64();
        endcase
    endfunction

    function automatic key_row_t fill_unused(input key_row_t cur, input int eff);
        key_row_t row;
        row = cur;
        for (int d = eff; d < INPUT_KEY_COLUMNS; d++)
            row[d] = rand64();
        return row;
    endfunction

    task automatic maybe_noise(input bit probe_phase);
        if ($urandom_range(0, 11) == 0)
        begin
            case ($urandom_range(0, probe_phase ? 3 : 2))
                0:       send_item(CMD_UNUSED, random_row());
                1:       send_item(CMD_PROBE, random_row());
                2:       send_item(CMD_APPEND, random_row());
                default: send_item(CMD_CLEAR, random_row());
            endcase
        end
    endtask

    task automatic run_random_join(input int join_idx);
        key_row_t         cur;
        key_row_t         right_q [$];
        key_row_t         left_q [$];
        logic [CFG_W-1:0] cfg_pick;
        int               eff;
        int               n;
        int               c;
        int               inc;
        int               dest;
        int               copies;
        int               pause_at;
        case (join_idx)
            0:       cfg_pick = 3'd1;
            1:       cfg_pick = 3'd4;
            2:       cfg_pick = 3'd0;
            3:       cfg_pick = 3'd7;
            default: cfg_pick = CFG_W'($urandom_range(0, 7));
        endcase
        write_key_columns(cfg_pick);
        idle_enable = ($urandom_range(0, 3) != 0);
        send_item(CMD_CLEAR, random_row());
        eff = effective_key_columns();
        for (int d = 0; d < INPUT_KEY_COLUMNS; d++)
            cur[d] = start_key();
        n = $urandom_range(6, 24);
        for (int t = 0; t < n; t++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                c   = $urandom_range(0, eff - 1);
                inc = $urandom_range(1, 3);
                if (cur[c] <= KEY_MAX - 64'(inc))
                begin
                    cur[c] = cur[c] + 64'(inc);
                    for (int d = c + 1; d < eff; d++)
                        cur[d] = rand64();
                end
            end
            copies = ($urandom_range(0, 9) == 0) ? 2 : 1;
            dest   = $urandom_range(0, 2);
            repeat (copies)
            begin
                if (dest != 1)
                    right_q.push_back(fill_unused(cur, eff));
                if (dest != 0)
                    left_q.push_back(fill_unused(cur, eff));
            end
        end
        foreach (right_q[i])
        begin
            maybe_noise(1'b0);
            send_item(CMD_APPEND, right_q[i]);
        end
        pause_at = (join_idx == 0 || $urandom_range(0, 7) == 0) ?
                   $urandom_range(0, left_q.size()) : -1;
        foreach (left_q[i])
        begin
            if (i == pause_at)
                wait_idle();
            maybe_noise(1'b1);
            send_item(CMD_PROBE, left_q[i]);
        end
    endtask

    task automatic test_random_joins();
        for (int j = 0; j < 8; j++)
            run_random_join(j);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        start    <= 1'b0;
        command  <= CMD_APPEND;
        key_col0 <= '0;
        key_col1 <= '0;
        key_col2 <= '0;
        key_col3 <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_single_column();
        test_multi_column();
        test_right_table_full();
        test_left_count_full();
        test_random_joins();

        wait_idle();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
